// ===== design/hss_pkg.sv =====
package hss_pkg;

  localparam logic [1:0] PHASE_U    = 2'd0;
  localparam logic [1:0] PHASE_V    = 2'd1;
  localparam logic [1:0] PHASE_W    = 2'd2;
  localparam logic [1:0] PHASE_NONE = 2'd3;

  localparam logic        DIRECTION_RESET   = 1'b1;
  localparam logic [15:0] STALL_LIMIT_RESET = 16'd15000;

  localparam logic [1:0] CFG_DIRECTION   = 2'd0;
  localparam logic [1:0] CFG_STALL_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    POS_HOLD = 2'd0,
    POS_INC  = 2'd1,
    POS_DEC  = 2'd2
  } pos_delta_t;

  typedef struct packed {
    logic [2:0]  hall_bits;
    logic [15:0] drive_level;
    logic        start_req;
    logic        halt;
  } in_t;

  typedef struct packed {
    logic [1:0]         high_phase;
    logic [1:0]         low_phase;
    logic [15:0]        pwm_compare;
    logic               bridge_enable;
    logic               hall_fault;
    logic signed [31:0] position;
    logic [31:0]        period_count;
    logic               period_valid;
    logic               stalled;
  } out_t;

  typedef struct packed {
    logic [1:0] high_phase;
    logic [1:0] low_phase;
  } phases_t;

  function automatic phases_t step_phases(input logic [2:0] step);
    phases_t p;
    case (step)
      3'd1:    p = '{high_phase: PHASE_U, low_phase: PHASE_W};
      3'd2:    p = '{high_phase: PHASE_V, low_phase: PHASE_U};
      3'd3:    p = '{high_phase: PHASE_V, low_phase: PHASE_W};
      3'd4:    p = '{high_phase: PHASE_W, low_phase: PHASE_V};
      3'd5:    p = '{high_phase: PHASE_U, low_phase: PHASE_V};
      3'd6:    p = '{high_phase: PHASE_W, low_phase: PHASE_U};
      default: p = '{high_phase: PHASE_NONE, low_phase: PHASE_NONE};
    endcase
    return p;
  endfunction

  function automatic pos_delta_t step_delta(input logic [2:0] prev, input logic [2:0] step);
    pos_delta_t d;
    case ({prev, step})
      6'o45, 6'o51, 6'o13, 6'o32, 6'o26, 6'o64: d = POS_DEC;
      6'o62, 6'o23, 6'o31, 6'o15, 6'o54, 6'o46: d = POS_INC;
      default:                                  d = POS_HOLD;
    endcase
    return d;
  endfunction

endpackage

// ===== design/hall_six_step_commutator.sv =====
// A result is registered in the output register when its request is accepted, or in the skid if the output stalls.
// Throughput: one request per cycle; when the output stalls, the result register
// plus a one-entry skid take one more request, then in_stall rises until drained.
// Reset (rst_n low, synchronous): stopped, counters and position zero,
// direction counter-clockwise, stall limit 15000, output buffer empty.
module hall_six_step_commutator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hss_pkg::in_t          in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hss_pkg::out_t         out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  logic        direction_r;
  logic [15:0] stall_limit_r;

  logic        running_r, running_nxt;
  logic [2:0]  prev_step_r, prev_step_nxt;
  logic        prev_top_r, prev_top_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [15:0] quiet_r, quiet_nxt;
  logic [31:0] pos_r, pos_nxt;

  logic          out_valid_r, skid_valid_r;
  hss_pkg::out_t out_r, skid_r;
  hss_pkg::out_t res;

  logic              in_fire, out_fire;
  logic              run_eff, step_ok, top, edge_hit;
  logic [2:0]        step;
  logic [31:0]       tick_inc;
  hss_pkg::phases_t  ph;
  hss_pkg::pos_delta_t delta;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;

  always_comb begin
    run_eff  = (running_r | in_data.start_req) & ~in_data.halt;
    step     = direction_r ? ~in_data.hall_bits : in_data.hall_bits;
    top      = in_data.hall_bits[2];
    step_ok  = (step != 3'd0) && (step != 3'd7);
    ph       = hss_pkg::step_phases(step);
    delta    = hss_pkg::step_delta(prev_step_r, step);
    tick_inc = (&tick_r) ? tick_r : tick_r + 32'd1;
    edge_hit = top != prev_top_r;

    running_nxt   = run_eff && step_ok;
    prev_step_nxt = prev_step_r;
    prev_top_nxt  = prev_top_r;
    tick_nxt      = tick_r;
    quiet_nxt     = quiet_r;
    pos_nxt       = pos_r;

    res.high_phase    = hss_pkg::PHASE_NONE;
    res.low_phase     = hss_pkg::PHASE_NONE;
    res.pwm_compare   = 16'd0;
    res.bridge_enable = 1'b0;
    res.hall_fault    = 1'b0;
    res.period_count  = 32'd0;
    res.period_valid  = 1'b0;
    res.stalled       = 1'b0;

    if (run_eff) begin
      if (step_ok) begin
        res.high_phase    = ph.high_phase;
        res.low_phase     = ph.low_phase;
        res.pwm_compare   = in_data.drive_level;
        res.bridge_enable = 1'b1;
      end else begin
        res.hall_fault = 1'b1;
      end
      if (edge_hit) begin
        prev_top_nxt = top;
        if (!top) begin
          res.period_count = tick_inc;
          res.period_valid = 1'b1;
        end
        tick_nxt  = 32'd0;
        quiet_nxt = 16'd0;
      end else if (quiet_r >= stall_limit_r) begin
        tick_nxt    = tick_inc;
        res.stalled = 1'b1;
        quiet_nxt   = 16'd0;
      end else begin
        tick_nxt  = tick_inc;
        quiet_nxt = quiet_r + 16'd1;
      end
      case (delta)
        hss_pkg::POS_INC: pos_nxt = pos_r + 32'd1;
        hss_pkg::POS_DEC: pos_nxt = pos_r - 32'd1;
        default:          pos_nxt = pos_r;
      endcase
      prev_step_nxt = step;
    end
    res.position = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r   <= hss_pkg::DIRECTION_RESET;
      stall_limit_r <= hss_pkg::STALL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hss_pkg::CFG_DIRECTION:   direction_r   <= cfg_data[0];
        hss_pkg::CFG_STALL_LIMIT: stall_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      prev_step_r <= 3'd0;
      prev_top_r  <= 1'b0;
      tick_r      <= 32'd0;
      quiet_r     <= 16'd0;
      pos_r       <= 32'd0;
    end else if (in_fire) begin
      running_r   <= running_nxt;
      prev_step_r <= prev_step_nxt;
      prev_top_r  <= prev_top_nxt;
      tick_r      <= tick_nxt;
      quiet_r     <= quiet_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!out_valid_r || out_fire) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (out_fire && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a request while output register is empty");

  a_fault_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.hall_fault) |->
      (!out_r.bridge_enable && out_r.high_phase == hss_pkg::PHASE_NONE))
    else $error("hall fault with bridge driven");

  a_enable_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.bridge_enable) |->
      (out_r.high_phase != hss_pkg::PHASE_NONE && out_r.low_phase != hss_pkg::PHASE_NONE))
    else $error("bridge enabled without a phase pair");

  a_halt_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.halt) |=> !running_r)
    else $error("halt did not stop the motor");

  a_stall_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.stalled) |=> (quiet_r == 16'd0))
    else $error("quiet counter not cleared on standstill");

endmodule

// ===== bench/tb.sv =====
module tb;

  localparam int LIMIT = 200000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  hss_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  hss_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = hss_pkg::CFG_DIRECTION;
  logic [15:0]   cfg_data = '0;

  hall_six_step_commutator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // clockwise successor and predecessor of each step, -1 for invalid steps
  int next_cw [8] = '{-1, 5, 3, 1, 6, 4, 2, -1};
  int prev_cw [8] = '{-1, 3, 6, 2, 5, 1, 4, -1};
  logic [1:0] high_of [8] = '{hss_pkg::PHASE_NONE, hss_pkg::PHASE_U, hss_pkg::PHASE_V,
                              hss_pkg::PHASE_V, hss_pkg::PHASE_W, hss_pkg::PHASE_U,
                              hss_pkg::PHASE_W, hss_pkg::PHASE_NONE};
  logic [1:0] low_of [8]  = '{hss_pkg::PHASE_NONE, hss_pkg::PHASE_W, hss_pkg::PHASE_U,
                              hss_pkg::PHASE_W, hss_pkg::PHASE_V, hss_pkg::PHASE_V,
                              hss_pkg::PHASE_U, hss_pkg::PHASE_NONE};

  // commutator state mirror
  logic        dir_cfg = hss_pkg::DIRECTION_RESET;
  logic [15:0] limit_cfg = hss_pkg::STALL_LIMIT_RESET;
  logic        run_st = 1'b0;
  logic [2:0]  last_step = '0;
  logic        last_top = 1'b0;
  logic [31:0] ticks = '0;
  logic [15:0] quiet = '0;
  logic [31:0] pos = '0;

  hss_pkg::in_t  pending [$];
  hss_pkg::out_t expected [$];
  int   errors = 0;
  int   got = 0;
  int   cycles = 0;
  int   choke_left = 0;
  bit   choked = 1'b0;
  bit   calm = 1'b0;
  logic [2:0] spin_step = 3'd1;
  bit   spin_cw = 1'b1;

  function automatic hss_pkg::out_t commutate(hss_pkg::in_t req);
    hss_pkg::out_t r;
    logic [2:0]    step;
    logic          top;
    r = '0;
    r.high_phase = hss_pkg::PHASE_NONE;
    r.low_phase = hss_pkg::PHASE_NONE;
    if (req.start_req) run_st = 1'b1;
    if (req.halt) run_st = 1'b0;
    if (run_st) begin
      step = dir_cfg ? 3'd7 - req.hall_bits : req.hall_bits;
      top = req.hall_bits[2];
      if (step != 3'd0 && step != 3'd7) begin
        r.high_phase = high_of[step];
        r.low_phase = low_of[step];
        r.pwm_compare = req.drive_level;
        r.bridge_enable = 1'b1;
      end else begin
        r.hall_fault = 1'b1;
        run_st = 1'b0;
      end
      if (ticks != '1) ticks++;
      if (top != last_top) begin
        last_top = top;
        if (!top) begin
          r.period_count = ticks;
          r.period_valid = 1'b1;
        end
        ticks = '0;
        quiet = '0;
      end else if (quiet >= limit_cfg) begin
        r.stalled = 1'b1;
        quiet = '0;
      end else begin
        quiet++;
      end
      if (step != last_step) begin
        if (next_cw[last_step] == step) pos++;
        else if (next_cw[step] == last_step) pos--;
        last_step = step;
      end
    end
    r.position = pos;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin : driver
    logic take;
    take = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (take) expected.push_back(commutate(in_data));
      if (!in_valid || take) begin
        if (pending.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
          in_valid <= 1'b1;
          in_data <= pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    hss_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got++;
        if (expected.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors++;
        end else begin
          want = expected.pop_front();
          check_field("high_phase", 32'(want.high_phase), 32'(out_data.high_phase));
          check_field("low_phase", 32'(want.low_phase), 32'(out_data.low_phase));
          check_field("pwm_compare", 32'(want.pwm_compare), 32'(out_data.pwm_compare));
          check_field("bridge_enable", 32'(want.bridge_enable),
                      32'(out_data.bridge_enable));
          check_field("hall_fault", 32'(want.hall_fault), 32'(out_data.hall_fault));
          check_field("position", want.position, out_data.position);
          check_field("period_count", want.period_count, out_data.period_count);
          check_field("period_valid", 32'(want.period_valid), 32'(out_data.period_valid));
          check_field("stalled", 32'(want.stalled), 32'(out_data.stalled));
        end
      end
      if (choke_left > 0) begin
        choke_left--;
        out_stall <= 1'b1;
      end else if (!choked && !calm && got >= 250 && pending.size() > 50) begin
        choked = 1'b1;
        choke_left = 200;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 6);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == hss_pkg::CFG_DIRECTION) dir_cfg = val[0];
    else limit_cfg = val;
  endtask

  task automatic drain();
    do @(posedge clk); while (pending.size() != 0 || in_valid || expected.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic push_req(logic [2:0] hall, logic [15:0] lvl, logic start, logic stop);
    hss_pkg::in_t r;
    r.hall_bits = hall;
    r.drive_level = lvl;
    r.start_req = start;
    r.halt = stop;
    pending.push_back(r);
  endtask

  // mostly clean rotation with reversals, dwells, bad codes, halts and restarts
  task automatic queue_spin(int n);
    hss_pkg::in_t r;
    int           roll;
    int           reps;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      reps = 1;
      r.drive_level = 16'($urandom);
      r.start_req = (i == 0) || ($urandom_range(99) < 8);
      if (roll < 4) begin
        r.hall_bits = $urandom_range(1) ? 3'd0 : 3'd7;
      end else if (roll < 8) begin
        r.hall_bits = 3'($urandom_range(7));
      end else begin
        if (roll < 14) spin_cw = !spin_cw;
        if (roll >= 14 && roll < 22) reps = $urandom_range(40, 2);
        else spin_step = spin_cw ? 3'(next_cw[spin_step]) : 3'(prev_cw[spin_step]);
        r.hall_bits = dir_cfg ? 3'd7 - spin_step : spin_step;
      end
      r.halt = (reps == 1) && ($urandom_range(99) < 2);
      repeat (reps) pending.push_back(r);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: counter-clockwise, step is 7 minus hall
    push_req(3'd3, 16'd1234, 1'b0, 1'b0);
    push_req(3'd6, 16'h0000, 1'b1, 1'b0);
    push_req(3'd2, 16'hFFFF, 1'b0, 1'b0);
    push_req(3'd3, 16'h8001, 1'b0, 1'b0);
    push_req(3'd1, 16'h7FFE, 1'b0, 1'b0);
    push_req(3'd5, 16'h00FF, 1'b0, 1'b0);
    push_req(3'd4, 16'hFF00, 1'b0, 1'b0);
    push_req(3'd6, 16'h5A5A, 1'b0, 1'b0);
    push_req(3'd4, 16'hA5A5, 1'b0, 1'b0);
    push_req(3'd5, 16'h0001, 1'b0, 1'b0);
    push_req(3'd5, 16'h0002, 1'b0, 1'b0);
    push_req(3'd7, 16'h1111, 1'b0, 1'b0);
    push_req(3'd6, 16'h2222, 1'b0, 1'b0);
    push_req(3'd6, 16'h3333, 1'b1, 1'b1);
    push_req(3'd0, 16'h4444, 1'b1, 1'b0);
    push_req(3'd6, 16'h5555, 1'b1, 1'b0);
    push_req(3'd2, 16'h6666, 1'b0, 1'b1);
    drain();

    // clockwise, zero limit: every quiet tick reports stalled
    write_reg(hss_pkg::CFG_DIRECTION, 16'd0);
    write_reg(hss_pkg::CFG_STALL_LIMIT, 16'd0);
    push_req(3'd1, 16'hFFFF, 1'b1, 1'b0);
    push_req(3'd1, 16'h0000, 1'b0, 1'b0);
    push_req(3'd1, 16'h1234, 1'b0, 1'b0);
    push_req(3'd5, 16'h4321, 1'b0, 1'b0);
    push_req(3'd4, 16'h0F0F, 1'b0, 1'b0);
    push_req(3'd0, 16'hF0F0, 1'b0, 1'b0);
    push_req(3'd4, 16'h0101, 1'b1, 1'b0);
    push_req(3'd7, 16'h1010, 1'b0, 1'b0);
    drain();

    write_reg(hss_pkg::CFG_STALL_LIMIT, 16'd3);
    queue_spin(40);
    drain();

    write_reg(hss_pkg::CFG_DIRECTION, 16'd1);
    write_reg(hss_pkg::CFG_STALL_LIMIT, 16'd1);
    calm = 1'b1;
    queue_spin(40);
    drain();
    calm = 1'b0;

    write_reg(hss_pkg::CFG_DIRECTION, 16'd0);
    write_reg(hss_pkg::CFG_STALL_LIMIT, 16'hFFFF);
    queue_spin(40);
    drain();

    write_reg(hss_pkg::CFG_DIRECTION, 16'd1);
    write_reg(hss_pkg::CFG_STALL_LIMIT, 16'd20);
    queue_spin(40);
    drain();

    write_reg(hss_pkg::CFG_DIRECTION, 16'($urandom_range(1)));
    write_reg(hss_pkg::CFG_STALL_LIMIT, 16'($urandom_range(12, 1)));
    queue_spin(40);
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== hall_six_step_commutator.f =====
design/hss_pkg.sv
design/hall_six_step_commutator.sv
bench/tb.sv
